// ===== hw/rtl/cfgl_pkg.sv =====
// Shared types and constants for the key=value configuration text lexer.
package cfgl_pkg;

    // Field widths
    localparam int LEN_W  = 11;
    localparam int LINE_W = 16;

    // Reset value of the token length limit
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 11'd1024;

    // Result queue between front and back (power of two depth)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Character codes
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_VT     = 8'd11;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_EQUAL  = 8'd61;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_UNDER  = 8'd95;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ID   = 3'd1,
        MODE_STR  = 3'd2,
        MODE_DEC  = 3'd3,
        MODE_SKIP = 3'd4
    } mode_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_SINGLE   = 3'd0,
        KIND_EQUAL    = 3'd1,
        KIND_IDENT    = 3'd2,
        KIND_STRING   = 3'd3,
        KIND_DECIMAL  = 3'd4,
        KIND_TEXT     = 3'd5,
        KIND_END      = 3'd6,
        KIND_TOO_LONG = 3'd7
    } kind_t;

    // One input request
    typedef struct packed {
        logic [7:0] byte_req;
        logic       end_of_input;
    } item_t;

    // One result
    typedef struct packed {
        kind_t             kind;
        logic [7:0]        value;
        logic [LEN_W-1:0]  token_length;
        logic [LINE_W-1:0] line_count;
        logic              last;
    } result_t;

    // All results of one request (one or two)
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } pair_t;

    // Write side of the result queue
    typedef struct packed {
        logic  valid;
        pair_t pair;
    } pair_push_t;

endpackage

// ===== hw/rtl/cfgl_front.sv =====
// Front end: accepts bytes, runs the lexer modes and forms the results of each request.
module cfgl_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  cfgl_pkg::item_t       item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [cfgl_pkg::LEN_W-1:0] cfg_data,
    input  logic                  q_full,
    output cfgl_pkg::pair_push_t  q_push
);

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= cfgl_pkg::CH_UPPER_A && c <= cfgl_pkg::CH_UPPER_Z) ||
                   (c >= cfgl_pkg::CH_LOWER_A && c <= cfgl_pkg::CH_LOWER_Z) ||
                   (c == cfgl_pkg::CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= cfgl_pkg::CH_ZERO && c <= cfgl_pkg::CH_NINE);
    endfunction

    function automatic cfgl_pkg::result_t mk_result(
        input cfgl_pkg::kind_t            k,
        input logic [7:0]                 v,
        input logic [cfgl_pkg::LEN_W-1:0] len
    );
        cfgl_pkg::result_t r;
        r              = '0;
        r.kind         = k;
        r.value        = v;
        r.token_length = len;
        mk_result      = r;
    endfunction

    // State
    cfgl_pkg::mode_t                mode_reg, mode_next;
    logic [cfgl_pkg::LEN_W-1:0]     count_reg, count_next;
    logic [7:0]                     prev_reg, prev_next;
    logic                           end_seen_reg, end_seen_next;
    logic [cfgl_pkg::LINE_W-1:0]    lines_reg, lines_next;
    logic [cfgl_pkg::LEN_W-1:0]     max_len_reg;

    logic                           accept;
    logic [7:0]                     c;
    logic [cfgl_pkg::LEN_W-1:0]     grow_cnt;
    logic                           line_inc;

    // Idle-mode decode of the current byte
    logic                           idle_valid;
    cfgl_pkg::result_t              idle_res;
    cfgl_pkg::mode_t                idle_mode;
    logic                           idle_start;
    logic                           idle_quote;
    logic                           idle_line;

    // Results of this request
    logic                           v0, v1;
    cfgl_pkg::result_t              r0, r1;

    assign accept    = push && !full;
    assign full      = q_full;
    assign cfg_ready = 1'b1;
    assign c         = item.byte_req;
    assign grow_cnt  = count_reg + 11'd1;

    // Idle-mode classification
    always_comb
    begin
        idle_valid = 1'b0;
        idle_res   = '0;
        idle_mode  = cfgl_pkg::MODE_IDLE;
        idle_start = 1'b0;
        idle_quote = 1'b0;
        idle_line  = 1'b0;
        priority if (c == cfgl_pkg::CH_NL)
        begin
            idle_line  = 1'b1;
            idle_valid = 1'b1;
            idle_res   = mk_result(cfgl_pkg::KIND_SINGLE, c, '0);
        end
        else if (c == cfgl_pkg::CH_SPACE || c == cfgl_pkg::CH_TAB ||
                 c == cfgl_pkg::CH_VT || c == cfgl_pkg::CH_CR)
        begin
            idle_valid = 1'b0;
        end
        else if (c == cfgl_pkg::CH_HASH)
        begin
            idle_mode = cfgl_pkg::MODE_SKIP;
        end
        else if (is_alpha(c))
        begin
            idle_mode  = cfgl_pkg::MODE_ID;
            idle_start = 1'b1;
            idle_valid = 1'b1;
            idle_res   = mk_result(cfgl_pkg::KIND_TEXT, c, '0);
        end
        else if (is_digit(c))
        begin
            idle_mode  = cfgl_pkg::MODE_DEC;
            idle_start = 1'b1;
            idle_valid = 1'b1;
            idle_res   = mk_result(cfgl_pkg::KIND_TEXT, c, '0);
        end
        else if (c == cfgl_pkg::CH_QUOTE)
        begin
            idle_mode  = cfgl_pkg::MODE_STR;
            idle_start = 1'b1;
            idle_quote = 1'b1;
        end
        else if (c == cfgl_pkg::CH_EQUAL)
        begin
            idle_valid = 1'b1;
            idle_res   = mk_result(cfgl_pkg::KIND_EQUAL, 8'd0, '0);
        end
        else
        begin
            idle_valid = 1'b1;
            idle_res   = mk_result(cfgl_pkg::KIND_SINGLE, c, '0);
        end
    end

    // Mode step: next state and up to two results
    always_comb
    begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        prev_next     = prev_reg;
        end_seen_next = end_seen_reg;
        line_inc      = 1'b0;
        v0            = 1'b0;
        v1            = 1'b0;
        r0            = '0;
        r1            = '0;
        if (item.end_of_input)
        begin
            v0 = 1'b1;
            if (!end_seen_reg)
            begin
                end_seen_next = 1'b1;
                mode_next     = cfgl_pkg::MODE_IDLE;
                count_next    = '0;
                r0            = mk_result(cfgl_pkg::KIND_SINGLE, cfgl_pkg::CH_NL, '0);
            end
            else
            begin
                r0 = mk_result(cfgl_pkg::KIND_END, 8'd0, '0);
            end
        end
        else
        begin
            unique case (mode_reg)
                cfgl_pkg::MODE_ID, cfgl_pkg::MODE_DEC:
                begin
                    if (is_digit(c) || (mode_reg == cfgl_pkg::MODE_ID && is_alpha(c)))
                    begin
                        // token grows
                        v0         = 1'b1;
                        r0         = mk_result(cfgl_pkg::KIND_TEXT, c, '0);
                        count_next = grow_cnt;
                        if (grow_cnt >= max_len_reg)
                        begin
                            v1         = 1'b1;
                            r1         = mk_result(cfgl_pkg::KIND_TOO_LONG, 8'd0, grow_cnt);
                            mode_next  = cfgl_pkg::MODE_IDLE;
                            count_next = '0;
                        end
                    end
                    else
                    begin
                        // token ends; the byte is lexed again in idle mode
                        v0 = 1'b1;
                        r0 = mk_result((mode_reg == cfgl_pkg::MODE_ID) ?
                                       cfgl_pkg::KIND_IDENT : cfgl_pkg::KIND_DECIMAL,
                                       8'd0, count_reg);
                        mode_next  = idle_mode;
                        count_next = idle_start ? 11'd1 : 11'd0;
                        if (idle_quote)
                        begin
                            prev_next = c;
                        end
                        line_inc = idle_line;
                        v1       = idle_valid;
                        r1       = idle_res;
                    end
                end
                cfgl_pkg::MODE_STR:
                begin
                    if (c != cfgl_pkg::CH_QUOTE || prev_reg == cfgl_pkg::CH_BSLASH)
                    begin
                        prev_next  = c;
                        v0         = 1'b1;
                        r0         = mk_result(cfgl_pkg::KIND_TEXT, c, '0);
                        count_next = grow_cnt;
                        if (grow_cnt >= max_len_reg)
                        begin
                            // opening quote is not part of the reported length
                            v1         = 1'b1;
                            r1         = mk_result(cfgl_pkg::KIND_TOO_LONG, 8'd0,
                                                   grow_cnt - 11'd1);
                            mode_next  = cfgl_pkg::MODE_IDLE;
                            count_next = '0;
                        end
                    end
                    else
                    begin
                        v0 = 1'b1;
                        r0 = mk_result(cfgl_pkg::KIND_STRING, 8'd0,
                                       (count_reg != '0) ? count_reg - 11'd1 : '0);
                        mode_next  = cfgl_pkg::MODE_IDLE;
                        count_next = '0;
                    end
                end
                cfgl_pkg::MODE_SKIP:
                begin
                    if (c == cfgl_pkg::CH_NL)
                    begin
                        line_inc  = 1'b1;
                        mode_next = cfgl_pkg::MODE_IDLE;
                        v0        = 1'b1;
                        r0        = mk_result(cfgl_pkg::KIND_SINGLE, c, '0);
                    end
                end
                default:
                begin
                    mode_next = idle_mode;
                    if (idle_start)
                    begin
                        count_next = 11'd1;
                    end
                    if (idle_quote)
                    begin
                        prev_next = c;
                    end
                    line_inc = idle_line;
                    v0       = idle_valid;
                    r0       = idle_res;
                end
            endcase
        end
    end

    // Saturating line counter
    assign lines_next = (line_inc && lines_reg != '1) ? lines_reg + 16'd1 : lines_reg;

    // Queue write: stamp line count and last flags
    always_comb
    begin
        q_push                      = '0;
        q_push.valid                = accept && v0;
        q_push.pair.two             = v1;
        q_push.pair.r0              = r0;
        q_push.pair.r0.line_count   = lines_next;
        q_push.pair.r0.last         = !v1;
        q_push.pair.r1              = r1;
        q_push.pair.r1.line_count   = lines_next;
        q_push.pair.r1.last         = 1'b1;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= cfgl_pkg::MODE_IDLE;
            count_reg    <= '0;
            prev_reg     <= '0;
            end_seen_reg <= 1'b0;
            lines_reg    <= '0;
            max_len_reg  <= cfgl_pkg::MAX_LEN_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= cfg_data;
            end
            if (accept)
            begin
                mode_reg     <= mode_next;
                count_reg    <= count_next;
                prev_reg     <= prev_next;
                end_seen_reg <= end_seen_next;
                lines_reg    <= lines_next;
            end
        end
    end

endmodule

// ===== hw/rtl/cfgl_queue.sv =====
// Short queue of per-request result groups between front and back.
module cfgl_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfgl_pkg::pair_push_t push,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output cfgl_pkg::pair_t      head
);

    cfgl_pkg::pair_t                 mem_reg [cfgl_pkg::QUEUE_DEPTH];
    logic [cfgl_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [cfgl_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            wr_en, rd_en;

    assign full  = (count_reg == cfgl_pkg::QCNT_W'(cfgl_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push.valid && !full;
    assign rd_en = pop && !empty;
    assign head  = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + cfgl_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - cfgl_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= push.pair;
        end
    end

    // Pointers wrap naturally at the power-of-two depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + cfgl_pkg::QPTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + cfgl_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/cfgl_back.sv =====
// Back end: holds one result group and hands its results out one at a time.
module cfgl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cfgl_pkg::pair_t   head,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output cfgl_pkg::result_t result
);

    cfgl_pkg::pair_t cur_reg;
    logic            valid_reg, valid_next;
    logic            second_reg, second_next;
    logic            done;
    logic            advance;
    logic            load;

    assign empty   = !valid_reg;
    assign result  = second_reg ? cur_reg.r1 : cur_reg.r0;
    assign done    = valid_reg && pop && (second_reg || !cur_reg.two);
    assign advance = valid_reg && pop && !second_reg && cur_reg.two;
    assign load    = (!valid_reg || done) && !q_empty;
    assign q_pop   = load;

    // Output slot control
    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        priority if (load)
        begin
            valid_next  = 1'b1;
            second_next = 1'b0;
        end
        else if (done)
        begin
            valid_next  = 1'b0;
            second_next = 1'b0;
        end
        else if (advance)
        begin
            second_next = 1'b1;
        end
    end

    // Result group payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    // Second result is only shown for a two-result group
    a_second_two: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && second_reg |-> cur_reg.two)
        else $error("second result shown for a single-result group");

    // The shown result is marked last exactly when it closes its group
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (result.last == (second_reg || !cur_reg.two)))
        else $error("last flag does not match group position");

    // Taking the first of two results moves on to the second
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> valid_reg && second_reg)
        else $error("second result of group lost");

endmodule

// ===== hw/rtl/config_text_lexer_unit.sv =====
// Top level of the key=value configuration text lexer.
//
// Input channel: one request per accepted push (push high, full low) carries
// one text byte or an end-of-input mark. Each request gives zero, one or two
// results. Result channel: while empty is low the oldest result is on result;
// it is taken when pop is high. The last result of a request has last set.
// Configuration: the token length limit is written through cfg_valid and
// cfg_data; cfg_ready is always high. Write it only while the lexer is idle.
// Path: an accepted request writes its result group into the queue; the
// output slot register loads it from there before it shows on result.
// Throughput: one request per cycle while full is low; results leave at one
// per cycle while pop is high, so requests that give two results drain at
// half rate. The front lexer step is combinational; a four-entry queue of
// result groups and a one-group output slot sit between front and back.
// Receiver stall: the queue fills and full rises; the lexer state holds.
// Reset: lexer idle, counts and line count zero, limit 1024, queue empty.
module config_text_lexer_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  cfgl_pkg::item_t            item,
    output logic                       empty,
    input  logic                       pop,
    output cfgl_pkg::result_t          result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cfgl_pkg::LEN_W-1:0] cfg_data
);

    cfgl_pkg::pair_push_t q_push;
    cfgl_pkg::pair_t      q_head;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;

    // Lexer front end
    cfgl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push)
    );

    // Result group queue
    cfgl_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .head  (q_head)
    );

    // Result serializer
    cfgl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the configuration text lexer: byte stimulus, result prediction.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEGMENT_ITEMS = 95;
    localparam int DRAIN_LIMIT   = 100000;

    // Tracks the lexer state, predicts results per request and checks them
    class lexer_scoreboard;
        cfgl_pkg::result_t                expected_results[$];
        cfgl_pkg::result_t                step_results[$];
        logic [cfgl_pkg::LEN_W-1:0]       token_limit;
        cfgl_pkg::mode_t                  mode;
        logic [cfgl_pkg::LEN_W-1:0]       tok_len;
        logic [7:0]                       prev_str;
        bit                               end_seen;
        logic [cfgl_pkg::LINE_W-1:0]      lines;
        int unsigned                      fails;

        function new();
            token_limit = cfgl_pkg::MAX_LEN_RESET;
            mode        = cfgl_pkg::MODE_IDLE;
            tok_len     = '0;
            prev_str    = '0;
            end_seen    = 1'b0;
            lines       = '0;
            fails       = 0;
        endfunction

        function void set_limit(logic [cfgl_pkg::LEN_W-1:0] v);
            token_limit = v;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string msg);
            if (fails < 100)
                $display("MISMATCH: %s", msg);
            fails++;
        endtask

        function bit is_alpha(logic [7:0] c);
            return (c >= cfgl_pkg::CH_UPPER_A && c <= cfgl_pkg::CH_UPPER_Z) ||
                   (c >= cfgl_pkg::CH_LOWER_A && c <= cfgl_pkg::CH_LOWER_Z) ||
                   c == cfgl_pkg::CH_UNDER;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= cfgl_pkg::CH_ZERO && c <= cfgl_pkg::CH_NINE;
        endfunction

        function void add(cfgl_pkg::kind_t k, logic [7:0] v,
                          logic [cfgl_pkg::LEN_W-1:0] len);
            cfgl_pkg::result_t r;
            r.kind         = k;
            r.value        = v;
            r.token_length = len;
            r.line_count   = '0;
            r.last         = 1'b0;
            step_results.push_back(r);
        endfunction

        function void count_line();
            if (lines != '1)
                lines++;
        endfunction

        // Append one byte to the open token; flag too long at the limit
        function void grow(logic [7:0] c, logic [cfgl_pkg::LEN_W-1:0] skip);
            tok_len = tok_len + 11'd1;
            add(cfgl_pkg::KIND_TEXT, c, '0);
            if (tok_len >= token_limit)
            begin
                add(cfgl_pkg::KIND_TOO_LONG, 8'd0, tok_len - skip);
                mode    = cfgl_pkg::MODE_IDLE;
                tok_len = '0;
            end
        endfunction

        function void idle_byte(logic [7:0] c);
            if (c == cfgl_pkg::CH_NL)
            begin
                count_line();
                add(cfgl_pkg::KIND_SINGLE, c, '0);
            end
            else if (c == cfgl_pkg::CH_SPACE || c == cfgl_pkg::CH_TAB ||
                     c == cfgl_pkg::CH_VT || c == cfgl_pkg::CH_CR)
            begin
                // blank: nothing
            end
            else if (c == cfgl_pkg::CH_HASH)
                mode = cfgl_pkg::MODE_SKIP;
            else if (is_alpha(c))
            begin
                mode    = cfgl_pkg::MODE_ID;
                tok_len = 11'd1;
                add(cfgl_pkg::KIND_TEXT, c, '0);
            end
            else if (is_digit(c))
            begin
                mode    = cfgl_pkg::MODE_DEC;
                tok_len = 11'd1;
                add(cfgl_pkg::KIND_TEXT, c, '0);
            end
            else if (c == cfgl_pkg::CH_QUOTE)
            begin
                mode     = cfgl_pkg::MODE_STR;
                tok_len  = 11'd1;
                prev_str = c;
            end
            else if (c == cfgl_pkg::CH_EQUAL)
                add(cfgl_pkg::KIND_EQUAL, 8'd0, '0);
            else
                add(cfgl_pkg::KIND_SINGLE, c, '0);
        endfunction

        // Accepted request: compute its results and queue them
        function void note_request(cfgl_pkg::item_t it);
            logic [7:0]        c;
            cfgl_pkg::result_t r;
            c = it.byte_req;
            step_results.delete();
            if (it.end_of_input)
            begin
                if (!end_seen)
                begin
                    end_seen = 1'b1;
                    mode     = cfgl_pkg::MODE_IDLE;
                    tok_len  = '0;
                    add(cfgl_pkg::KIND_SINGLE, cfgl_pkg::CH_NL, '0);
                end
                else
                    add(cfgl_pkg::KIND_END, 8'd0, '0);
            end
            else
            begin
                case (mode)
                    cfgl_pkg::MODE_ID:
                        if (is_alpha(c) || is_digit(c))
                            grow(c, '0);
                        else
                        begin
                            add(cfgl_pkg::KIND_IDENT, 8'd0, tok_len);
                            mode    = cfgl_pkg::MODE_IDLE;
                            tok_len = '0;
                            idle_byte(c);
                        end
                    cfgl_pkg::MODE_DEC:
                        if (is_digit(c))
                            grow(c, '0);
                        else
                        begin
                            add(cfgl_pkg::KIND_DECIMAL, 8'd0, tok_len);
                            mode    = cfgl_pkg::MODE_IDLE;
                            tok_len = '0;
                            idle_byte(c);
                        end
                    cfgl_pkg::MODE_STR:
                        // a quote right after a backslash stays in the string
                        if (c != cfgl_pkg::CH_QUOTE || prev_str == cfgl_pkg::CH_BSLASH)
                        begin
                            prev_str = c;
                            grow(c, 11'd1);
                        end
                        else
                        begin
                            add(cfgl_pkg::KIND_STRING, 8'd0,
                                (tok_len != '0) ? tok_len - 11'd1 : '0);
                            mode    = cfgl_pkg::MODE_IDLE;
                            tok_len = '0;
                        end
                    cfgl_pkg::MODE_SKIP:
                        if (c == cfgl_pkg::CH_NL)
                        begin
                            count_line();
                            mode = cfgl_pkg::MODE_IDLE;
                            add(cfgl_pkg::KIND_SINGLE, c, '0);
                        end
                    default:
                    begin
                        mode = cfgl_pkg::MODE_IDLE;
                        idle_byte(c);
                    end
                endcase
            end
            foreach (step_results[i])
            begin
                r            = step_results[i];
                r.line_count = lines;
                r.last       = (i == step_results.size() - 1);
                expected_results.push_back(r);
            end
        endfunction

        // Accepted result: compare against the oldest expectation
        task check_result(cfgl_pkg::result_t got);
            cfgl_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d value %0d",
                                 got.kind, got.value));
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind got %0d want %0d", got.kind, want.kind));
            if (got.value !== want.value)
                report($sformatf("value got %0d want %0d", got.value, want.value));
            if (got.token_length !== want.token_length)
                report($sformatf("token_length got %0d want %0d",
                                 got.token_length, want.token_length));
            if (got.line_count !== want.line_count)
                report($sformatf("line_count got %0d want %0d",
                                 got.line_count, want.line_count));
            if (got.last !== want.last)
                report($sformatf("last got %0d want %0d", got.last, want.last));
        endtask
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       push      = 1'b0;
    logic                       full;
    cfgl_pkg::item_t            item      = '0;
    logic                       empty;
    logic                       pop       = 1'b0;
    cfgl_pkg::result_t          result;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [cfgl_pkg::LEN_W-1:0] cfg_data  = '0;

    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    bit               rx_hold_req = 1'b0;
    int               items_sent  = 0;
    lexer_scoreboard  sb;

    config_text_lexer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Watch both handshakes at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_request(item);
            if (pop && !empty)
                sb.check_result(result);
        end
    end

    // Result side: random pop, with one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Run guard
    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    // Offer one request after a random gap; return at its acceptance edge
    task send_request(cfgl_pkg::item_t it);
        int gap;
        gap = 0;
        while (gap < 50 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task send_char(logic [7:0] c);
        cfgl_pkg::item_t it;
        it.byte_req     = c;
        it.end_of_input = 1'b0;
        send_request(it);
    endtask

    task send_end(logic [7:0] c);
        cfgl_pkg::item_t it;
        it.byte_req     = c;
        it.end_of_input = 1'b1;
        send_request(it);
    endtask

    task send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function logic [7:0] alpha_char();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'(cfgl_pkg::CH_UPPER_A + r);
        else if (r < 52)
            return 8'(cfgl_pkg::CH_LOWER_A + r - 26);
        return cfgl_pkg::CH_UNDER;
    endfunction

    function logic [7:0] digit_char();
        return 8'(cfgl_pkg::CH_ZERO + $urandom_range(0, 9));
    endfunction

    task send_blanks();
        int r;
        repeat ($urandom_range(0, 2))
        begin
            r = $urandom_range(0, 3);
            send_char(r == 0 ? cfgl_pkg::CH_SPACE : r == 1 ? cfgl_pkg::CH_TAB :
                      r == 2 ? cfgl_pkg::CH_VT : cfgl_pkg::CH_CR);
        end
    endtask

    // Identifier or decimal; now and then longer than small limits
    task send_token(bit numeric);
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
        send_char(numeric ? digit_char() : alpha_char());
        for (int i = 1; i < n; i++)
            if (numeric || $urandom_range(0, 3) == 0)
                send_char(digit_char());
            else
                send_char(alpha_char());
    endtask

    // Quoted string with arbitrary bytes and some escaped quotes
    task send_string();
        int         n;
        logic [7:0] b;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 8);
        send_char(cfgl_pkg::CH_QUOTE);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_char(cfgl_pkg::CH_BSLASH);
                send_char(cfgl_pkg::CH_QUOTE);
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
                send_char(b == cfgl_pkg::CH_QUOTE ? cfgl_pkg::CH_SPACE : b);
            end
        end
        if ($urandom_range(0, 15) != 0)
            send_char(cfgl_pkg::CH_QUOTE);
    endtask

    // One key = value line, sometimes with a trailing comment
    task send_line();
        int         pick;
        logic [7:0] b;
        send_blanks();
        send_token(1'b0);
        send_blanks();
        if ($urandom_range(0, 9) != 0)
            send_char(cfgl_pkg::CH_EQUAL);
        send_blanks();
        pick = $urandom_range(0, 2);
        if (pick == 0)
            send_token(1'b1);
        else if (pick == 1)
            send_string();
        else
            send_token(1'b0);
        send_blanks();
        if ($urandom_range(0, 3) == 0)
        begin
            send_char(cfgl_pkg::CH_HASH);
            repeat ($urandom_range(0, 5))
            begin
                b = 8'($urandom_range(0, 255));
                send_char(b == cfgl_pkg::CH_NL ? cfgl_pkg::CH_SPACE : b);
            end
        end
        send_char(cfgl_pkg::CH_NL);
    endtask

    // Stop offering and let every expected result come out
    task wait_drained();
        int guard;
        guard = 0;
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_limit(logic [cfgl_pkg::LEN_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_limit(v);
    endtask

    // Main sequence
    initial
    begin
        int                         pick;
        int                         target;
        logic [cfgl_pkg::LEN_W-1:0] limit;
        logic [7:0]                 b;

        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed: every token kind, blanks, comment, escaped quote, byte extremes, ends
        send_text("a9_ =09x");
        send_char(cfgl_pkg::CH_VT);
        send_text("#!\n\"\\\"\"");
        send_char(8'hFF);
        send_char(8'h00);
        send_char(cfgl_pkg::CH_CR);
        send_char(cfgl_pkg::CH_TAB);
        send_text("\nk");
        send_end(8'h00);
        send_end(8'hFF);
        send_text("7\n");

        // Smallest limit: too long on the second byte of each token kind
        wait_drained();
        write_limit(11'd2);
        send_text("ab\"x12\"\" \n");

        // Random phases: receiver idles, then sender idles, then neither
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 71 : 0;
            rx_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 34 : 0;
            for (int seg = 0; seg < 3; seg++)
            begin
                wait_drained();
                pick = $urandom_range(0, 3);
                if (ph == 2 && seg == 0)
                    limit = cfgl_pkg::MAX_LEN_RESET;
                else if (pick == 0)
                    limit = 11'd2;
                else if (pick == 1)
                    limit = cfgl_pkg::MAX_LEN_RESET;
                else
                    limit = 11'($urandom_range(3, 16));
                write_limit(limit);

                // long receiver stall while requests keep coming
                if (ph == 0 && seg == 0)
                    rx_hold_req = 1'b1;

                // one string that hits the largest limit
                if (ph == 2 && seg == 0)
                begin
                    if (sb.mode == cfgl_pkg::MODE_STR)
                    begin
                        send_char(cfgl_pkg::CH_SPACE);
                        send_char(cfgl_pkg::CH_QUOTE);
                    end
                    else
                        send_char(cfgl_pkg::CH_NL);
                    send_char(cfgl_pkg::CH_QUOTE);
                    repeat (1023)
                    begin
                        b = 8'($urandom_range(0, 255));
                        send_char(b == cfgl_pkg::CH_QUOTE ? cfgl_pkg::CH_SPACE : b);
                    end
                    send_char(cfgl_pkg::CH_NL);
                end

                target = items_sent + SEGMENT_ITEMS;
                while (items_sent < target)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                        send_line();
                    else if (pick < 95)
                        repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
                    else
                        send_end(8'($urandom_range(0, 255)));
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
